@@ rtl/ptss_pkg.sv @@
// Package for the periodic task slot scheduler.
// Holds slot count, request and status codes, and beat structs.
// No dependencies.
package ptss_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W       = $clog2(NUM_SLOTS + 1);
  localparam int MAX_RESULTS = 8;
  localparam int NUM_W       = $clog2(MAX_RESULTS);

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_ADD  = 2'd1;
  localparam logic [1:0] REQ_KILL = 2'd2;
  localparam logic [1:0] REQ_RUN  = 2'd3;

  localparam logic [2:0] ST_TICK_DONE  = 3'd0;
  localparam logic [2:0] ST_ADDED      = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_KILLED     = 3'd3;
  localparam logic [2:0] ST_INVALID    = 3'd4;
  localparam logic [2:0] ST_DISPATCH   = 3'd5;
  localparam logic [2:0] ST_NONE_READY = 3'd6;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] reload_interval;
    logic [31:0] first_delay;
    logic [7:0]  slot_number;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] slot_index;
    logic       one_shot_freed;
    logic       last;
  } rsp_t;

  typedef struct packed {
    logic [31:0] interval;
    logic [31:0] delay;
  } entry_t;

  typedef struct packed {
    entry_t wr_entry;
    logic   delay_zero;
    logic   iv_zero;
  } alu_res_t;

endpackage

@@ rtl/periodic_task_slot_scheduler.sv @@
// Periodic task slot scheduler: one request at a time, slots walked one per cycle
// but for a pause at each Run dispatch. Tick walks every slot; Add walks to a free one.
// Kill acts on its slot alone. Run issues a beat per ready slot, or none-ready if none.
// Next request accepted in the cycle after the last beat issues; stalls delay it.
// Reset clears control state and all active and ready flags at once; no clearing pass.
// Depends on ptss_pkg and ptss_slot_alu.
module periodic_task_slot_scheduler import ptss_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TICK   = 3'd1;
  localparam logic [2:0] S_ADD    = 3'd2;
  localparam logic [2:0] S_KILL   = 3'd3;
  localparam logic [2:0] S_RUN    = 3'd4;
  localparam logic [2:0] S_RUN_RD = 3'd5;

  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(NUM_SLOTS);

  logic [2:0]           state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [NUM_W-1:0]     n_q, n_d;
  logic                 p_vld_q, p_vld_d;
  logic [SLOT_W-1:0]    p_idx_q, p_idx_d;
  logic [NUM_SLOTS-1:0] active_q, active_d;
  logic [NUM_SLOTS-1:0] ready_q, ready_d;
  req_t                 req_q;
  logic                 out_vld_q, out_vld_d;
  rsp_t                 out_data_q, out_data_d;

  entry_t               mem_q [NUM_SLOTS];
  entry_t               rd_entry_q;
  logic [SLOT_W-1:0]    rd_addr, wr_addr, cur;
  logic                 wr_en;
  logic                 at_end, out_free, emit, any_above;
  rsp_t                 emit_data;
  logic [NUM_SLOTS-1:0] above_mask, pend;
  alu_res_t             alu_res;

  assign cur      = cnt_q[SLOT_W-1:0];
  assign at_end   = (cnt_q == CNT_END);
  assign rd_addr  = at_end ? '0 : cur;
  assign out_free = !out_vld_q || out_ready_i;
  assign pend     = active_q & ready_q;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      above_mask[i] = (CNT_W'(i) > cnt_q);
    end
  end
  assign any_above = |(pend & above_mask);

  ptss_slot_alu u_alu (
    .entry_i        (rd_entry_q),
    .is_add_i       (state_q == S_ADD),
    .add_interval_i (req_q.reload_interval),
    .add_delay_i    (req_q.first_delay),
    .res_o          (alu_res)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= alu_res.wr_entry;
    end
    rd_entry_q <= mem_q[rd_addr];
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    p_vld_d   = 1'b0;
    p_idx_d   = p_idx_q;
    active_d  = active_q;
    ready_d   = ready_q;
    wr_en     = 1'b0;
    wr_addr   = cur;
    emit      = 1'b0;
    emit_data = '{status: ST_TICK_DONE, slot_index: 3'd0, one_shot_freed: 1'b0, last: 1'b1};

    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        n_d   = '0;
        if (in_valid_i) begin
          case (in_data_i.req_type)
            REQ_TICK: state_d = S_TICK;
            REQ_ADD:  state_d = S_ADD;
            REQ_KILL: state_d = S_KILL;
            default:  state_d = S_RUN;
          endcase
        end
      end
      S_TICK: begin
        if (!at_end) begin
          cnt_d   = cnt_q + CNT_W'(1);
          p_vld_d = 1'b1;
          p_idx_d = cur;
        end
        if (p_vld_q && active_q[p_idx_q]) begin
          wr_en   = 1'b1;
          wr_addr = p_idx_q;
          if (alu_res.delay_zero) begin
            ready_d[p_idx_q] = 1'b1;
          end
        end
        if (at_end && !p_vld_q && out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_ADD: begin
        if (at_end) begin
          if (out_free) begin
            emit             = 1'b1;
            emit_data.status = ST_FULL;
            state_d          = S_IDLE;
          end
        end else if (!active_q[cur]) begin
          if (out_free) begin
            wr_en                = 1'b1;
            active_d[cur]        = 1'b1;
            ready_d[cur]         = 1'b0;
            emit                 = 1'b1;
            emit_data.status     = ST_ADDED;
            emit_data.slot_index = 3'(cnt_q);
            state_d              = S_IDLE;
          end
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_KILL: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          if (req_q.slot_number < 8'(NUM_SLOTS)) begin
            active_d[req_q.slot_number[SLOT_W-1:0]] = 1'b0;
            ready_d[req_q.slot_number[SLOT_W-1:0]]  = 1'b0;
            emit_data.status     = ST_KILLED;
            emit_data.slot_index = req_q.slot_number[2:0];
          end else begin
            emit_data.status = ST_INVALID;
          end
        end
      end
      S_RUN: begin
        if (at_end) begin
          if (out_free) begin
            emit             = 1'b1;
            emit_data.status = ST_NONE_READY;
            state_d          = S_IDLE;
          end
        end else if (pend[cur]) begin
          state_d = S_RUN_RD;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_RUN_RD: begin
        if (out_free) begin
          emit                     = 1'b1;
          emit_data.status         = ST_DISPATCH;
          emit_data.slot_index     = 3'(cnt_q);
          emit_data.one_shot_freed = alu_res.iv_zero;
          emit_data.last           = (n_q == NUM_W'(MAX_RESULTS - 1)) || !any_above;
          ready_d[cur]             = 1'b0;
          if (alu_res.iv_zero) begin
            active_d[cur] = 1'b0;
          end
          n_d = n_q + NUM_W'(1);
          if (emit_data.last) begin
            state_d = S_IDLE;
          end else begin
            cnt_d   = cnt_q + CNT_W'(1);
            state_d = S_RUN;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    if (emit) begin
      out_vld_d  = 1'b1;
      out_data_d = emit_data;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      n_q       <= '0;
      p_vld_q   <= 1'b0;
      active_q  <= '0;
      ready_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      n_q       <= n_d;
      p_vld_q   <= p_vld_d;
      active_q  <= active_d;
      ready_q   <= ready_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_idx_q    <= p_idx_d;
    out_data_q <= out_data_d;
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

endmodule

@@ rtl/ptss_slot_alu.sv @@
// Shared slot update unit: decrement, reload, add load and zero checks of one entry.
// Depends on ptss_pkg.
module ptss_slot_alu import ptss_pkg::*; (
  input  entry_t      entry_i,
  input  logic        is_add_i,
  input  logic [31:0] add_interval_i,
  input  logic [31:0] add_delay_i,
  output alu_res_t    res_o
);

  always_comb begin
    res_o.delay_zero = (entry_i.delay == 32'd0);
    res_o.iv_zero    = (entry_i.interval == 32'd0);
    if (is_add_i) begin
      res_o.wr_entry.interval = add_interval_i;
      res_o.wr_entry.delay    = add_delay_i;
    end else if (res_o.delay_zero) begin
      res_o.wr_entry.interval = entry_i.interval;
      res_o.wr_entry.delay    = entry_i.interval;
    end else begin
      res_o.wr_entry.interval = entry_i.interval;
      res_o.wr_entry.delay    = entry_i.delay - 32'd1;
    end
  end

endmodule

@@ rtl/ptss_checker.sv @@
// Port-level checks for the periodic task slot scheduler, bound to the top level.
// Depends on ptss_pkg and periodic_task_slot_scheduler.
module ptss_checker import ptss_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input req_t in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while a request is in work");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status != 3'd7)
    else $error("undefined status code");

  a_freed_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.one_shot_freed |-> out_data_o.status == ST_DISPATCH)
    else $error("slot freed outside a dispatch");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_DISPATCH |-> out_data_o.last)
    else $error("single-beat reply without last");

endmodule

bind periodic_task_slot_scheduler ptss_checker u_ptss_checker (.*);
